// ----- rtl/ordinal_block_mean_rank_assert.svh -----
// Assertion macros for the checker file.
`ifndef ORDINAL_BLOCK_MEAN_RANK_ASSERT_SVH
`define ORDINAL_BLOCK_MEAN_RANK_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define OBMR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define OBMR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/obmr_pkg.sv -----
`timescale 1ns / 1ps

package obmr_pkg;

  localparam int unsigned MAX_GRID      = 8;
  localparam int unsigned MAX_DIMENSION = 4096;

  localparam int unsigned NUM_AREAS = MAX_GRID * MAX_GRID;
  localparam int unsigned POS_W     = $clog2(MAX_DIMENSION);
  localparam int unsigned DIM_W     = POS_W + 1;
  localparam int unsigned GIDX_W    = $clog2(MAX_GRID);
  localparam int unsigned GRID_W    = GIDX_W + 1;
  localparam int unsigned AREA_W    = $clog2(NUM_AREAS);

  // Fixed field and register widths
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned DIM_CFG_W   = 13;
  localparam int unsigned GRID_CFG_W  = 4;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned RANK_W      = 6;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - INDEX_W - RANK_W;

  localparam logic [DIM_CFG_W-1:0]  RESET_WIDTH  = 13'd640;
  localparam logic [DIM_CFG_W-1:0]  RESET_HEIGHT = 13'd480;
  localparam logic [GRID_CFG_W-1:0] RESET_GRID   = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_GRID_SIZE    = 2'd2
  } obmr_reg_e;

  typedef struct packed {
    logic run;
    logic div_start;
    logic div_sel_h;
    logic load_aw;
    logic load_ah;
    logic clr_i;
    logic inc_i;
    logic rd_i;
    logic clr_j;
    logic sweep;
    logic cap_sum;
    logic out_load;
  } obmr_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic div_done;
    logic eof;
    logic sweep_end;
    logic last_area;
    logic out_taken;
  } obmr_status_t;

endpackage

// ----- rtl/obmr_ram.sv -----
`timescale 1ns / 1ps

module obmr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/obmr_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module obmr_div import obmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIM_W-1:0]  dividend_i,
  input  logic [GRID_W-1:0] divisor_i,
  output logic [DIM_W-1:0]  quotient_o,
  output logic              done_o
);

  localparam int unsigned CNT_W = $clog2(DIM_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIM_W-1:0]  quo_q, quo_d;
  logic [GRID_W-1:0] rem_q, rem_d;
  logic [GRID_W-1:0] dsr_q, dsr_d;
  logic [GRID_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DIM_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    if (start_i) begin
      cnt_d = CNT_W'(DIM_W);
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[DIM_W-2:0], fits};
      if (fits) begin
        rem_d = GRID_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[GRID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = (cnt_q == '0);

endmodule

// ----- rtl/obmr_dp.sv -----
`timescale 1ns / 1ps

module obmr_dp import obmr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [PIX_W-1:0]       s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  obmr_cmd_t              cmd_i,
  output obmr_status_t           status_o
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (32'(v) > MAX_DIMENSION) begin
      return DIM_W'(MAX_DIMENSION);
    end
    return DIM_W'(v);
  endfunction

  function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_CFG_W-1:0] v);
    if (v == '0) begin
      return GRID_W'(1);
    end
    if (32'(v) > MAX_GRID) begin
      return GRID_W'(MAX_GRID);
    end
    return GRID_W'(v);
  endfunction

  // Configuration
  logic [DIM_CFG_W-1:0]  width_q, height_q;
  logic [GRID_CFG_W-1:0] grid_q;
  logic                  cfg_hit;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == REG_FRAME_WIDTH) ||
                                (cfg_idx_i == REG_FRAME_HEIGHT) ||
                                (cfg_idx_i == REG_GRID_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      grid_q   <= RESET_GRID;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
        REG_GRID_SIZE:    grid_q   <= cfg_data_i[GRID_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [GRID_W-1:0]   g_eff;
  logic [2*GRID_W-1:0] area_cnt, area_cnt_m1;
  logic [AREA_W-1:0]   nm1;

  assign w_eff       = clamp_dim(width_q);
  assign h_eff       = clamp_dim(height_q);
  assign g_eff       = clamp_grid(grid_q);
  assign area_cnt    = (2*GRID_W)'(g_eff) * (2*GRID_W)'(g_eff);
  assign area_cnt_m1 = area_cnt - (2*GRID_W)'(1);
  assign nm1         = area_cnt_m1[AREA_W-1:0];

  // Area size: frame dimension over grid size
  logic [DIM_W-1:0] quo;
  logic             div_done;
  logic [DIM_W-1:0] aw_q, ah_q;

  obmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel_h ? h_eff : w_eff),
    .divisor_i  (g_eff),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= '0;
      ah_q <= '0;
    end else begin
      if (cmd_i.load_aw) begin
        aw_q <= quo;
      end
      if (cmd_i.load_ah) begin
        ah_q <= quo;
      end
    end
  end

  logic degen;
  assign degen = (aw_q == '0) || (ah_q == '0);

  // Pixel position tracking
  logic [POS_W-1:0]  col_q, row_q, sub_col_q, sub_row_q;
  logic [GRID_W-1:0] ac_q, ar_q;
  logic [AREA_W:0]   row_base_q;
  logic              accept, eol, last_row, eof;
  logic              col_end_area, row_end_area, area_done, in_grid, acc_en;

  assign accept       = s_axis_tvalid_i && cmd_i.run;
  assign eol          = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
  assign last_row     = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;
  assign eof          = accept && eol && last_row;
  assign col_end_area = DIM_W'(sub_col_q) == (aw_q - DIM_W'(1));
  assign row_end_area = DIM_W'(sub_row_q) == (ah_q - DIM_W'(1));
  assign area_done    = col_end_area && row_end_area;
  assign in_grid      = !degen && (ac_q < g_eff) && (ar_q < g_eff);
  assign acc_en       = accept && in_grid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      sub_col_q  <= '0;
      sub_row_q  <= '0;
      ac_q       <= '0;
      ar_q       <= '0;
      row_base_q <= '0;
    end else if (cfg_hit || eof) begin
      col_q      <= '0;
      row_q      <= '0;
      sub_col_q  <= '0;
      sub_row_q  <= '0;
      ac_q       <= '0;
      ar_q       <= '0;
      row_base_q <= '0;
    end else if (accept) begin
      if (eol) begin
        col_q     <= '0;
        sub_col_q <= '0;
        ac_q      <= '0;
        row_q     <= row_q + POS_W'(1);
        if (row_end_area) begin
          sub_row_q <= '0;
          if (ar_q < g_eff) begin
            ar_q       <= ar_q + GRID_W'(1);
            row_base_q <= row_base_q + (AREA_W+1)'(g_eff);
          end
        end else begin
          sub_row_q <= sub_row_q + POS_W'(1);
        end
      end else begin
        col_q <= col_q + POS_W'(1);
        if (col_end_area) begin
          sub_col_q <= '0;
          if (ac_q < g_eff) begin
            ac_q <= ac_q + GRID_W'(1);
          end
        end else begin
          sub_col_q <= sub_col_q + POS_W'(1);
        end
      end
    end
  end

  // One partial sum per area column of the current area row; an area's
  // sum goes to the RAM on its last pixel.
  logic [SUM_W-1:0]  row_sum_q [MAX_GRID];
  logic [GIDX_W-1:0] aci;
  logic [SUM_W-1:0]  acc;
  logic [AREA_W:0]   wr_full;

  assign aci     = ac_q[GIDX_W-1:0];
  assign acc     = row_sum_q[aci] + SUM_W'(s_axis_tdata_i);
  assign wr_full = row_base_q + (AREA_W+1)'(ac_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_GRID; k++) begin
        row_sum_q[k] <= '0;
      end
    end else if (cfg_hit || eof) begin
      for (int k = 0; k < MAX_GRID; k++) begin
        row_sum_q[k] <= '0;
      end
    end else if (acc_en) begin
      row_sum_q[aci] <= area_done ? '0 : acc;
    end
  end

  // Area sum store and rank sweep
  logic [AREA_W-1:0] i_q, j_q, rd_addr;
  logic [SUM_W-1:0]  rdata, sum_i_q;
  logic [RANK_W-1:0] rank_q;

  assign rd_addr = cmd_i.rd_i ? i_q : (cmd_i.sweep ? j_q + AREA_W'(1) : j_q);

  obmr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_AREAS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (acc_en && area_done),
    .waddr_i (wr_full[AREA_W-1:0]),
    .wdata_i (acc),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      rank_q <= '0;
    end else begin
      if (cmd_i.clr_i) begin
        i_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + AREA_W'(1);
      end
      if (cmd_i.clr_j) begin
        j_q <= '0;
      end else if (cmd_i.sweep) begin
        j_q <= j_q + AREA_W'(1);
      end
      if (cmd_i.cap_sum) begin
        rank_q <= '0;
      end else if (cmd_i.sweep && !degen && (rdata < sum_i_q)) begin
        rank_q <= rank_q + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_sum) begin
      sum_i_q <= rdata;
    end
  end

  // Output register
  logic              out_valid_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [RANK_W-1:0] out_rank_q;
  logic              out_last_q;
  logic              out_taken;

  assign out_taken = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cfg_hit) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= INDEX_W'(i_q);
      out_rank_q <= rank_q;
      out_last_q <= (i_q == nm1);
    end
  end

  assign s_axis_tready_o = cmd_i.run;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_rank_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

  assign status_o.cfg_hit   = cfg_hit;
  assign status_o.div_done  = div_done;
  assign status_o.eof       = eof;
  assign status_o.sweep_end = (j_q == nm1);
  assign status_o.last_area = (i_q == nm1);
  assign status_o.out_taken = out_taken;

endmodule

// ----- rtl/obmr_ctrl.sv -----
`timescale 1ns / 1ps

module obmr_ctrl import obmr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  obmr_status_t status_i,
  output obmr_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_SETW  = 10'b00_0000_0001,
    S_DIVW  = 10'b00_0000_0010,
    S_SETH  = 10'b00_0000_0100,
    S_DIVH  = 10'b00_0000_1000,
    S_RUN   = 10'b00_0001_0000,
    S_LOAD  = 10'b00_0010_0000,
    S_CAP   = 10'b00_0100_0000,
    S_SWEEP = 10'b00_1000_0000,
    S_PUT   = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } obmr_state_e;

  obmr_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_SETW: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (status_i.div_done) begin
          cmd_o.load_aw = 1'b1;
          state_d       = S_SETH;
        end
      end
      S_SETH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_h = 1'b1;
        state_d         = S_DIVH;
      end
      S_DIVH: begin
        if (status_i.div_done) begin
          cmd_o.load_ah = 1'b1;
          state_d       = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (status_i.eof) begin
          cmd_o.clr_i = 1'b1;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.rd_i  = 1'b1;
        cmd_o.clr_j = 1'b1;
        state_d     = S_CAP;
      end
      S_CAP: begin
        cmd_o.cap_sum = 1'b1;
        state_d       = S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_end) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_taken) begin
          if (status_i.last_area) begin
            state_d = S_RUN;
          end else begin
            cmd_o.inc_i = 1'b1;
            state_d     = S_LOAD;
          end
        end
      end
      default: state_d = S_SETW;
    endcase
    // a register write restarts the frame and the area size calculation
    if (status_i.cfg_hit) begin
      cmd_o   = '0;
      state_d = S_SETW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SETW;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/ordinal_block_mean_rank.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Signals             Payload (low bit up)
// s_axis    in   tvalid/tready/tdata pixel[7:0]
// m_axis    out  tvalid/tready/tdata area_index[5:0], rank[11:6], zero pad[15:12]
//                tlast               last area of the frame
// cfg       in   we/idx/data         frame_width=0, frame_height=1, grid_size=2
//
// Pixels: one item per cycle while a frame streams in.
// After the last pixel: g*g results, each in turn through load, capture, a sweep
// with one RAM read per area, output load and handoff to a ready consumer.
// After reset or any register write, tready stays low while the
// shared bit-serial divider works out area width and then area height.
// Input stalls only delay counting; output stalls hold the result register.
module ordinal_block_mean_rank import obmr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PIX_W-1:0]       s_axis_tdata,  // pixel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // area_index, rank, pad
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  obmr_cmd_t    cmd;
  obmr_status_t status;

  obmr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  obmr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

// ----- rtl/obmr_chk.sv -----
`timescale 1ns / 1ps
`include "ordinal_block_mean_rank_assert.svh"

module obmr_chk import obmr_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // stalled result keeps its payload
  `OBMR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "result payload changed while stalled")

  // pixels are never taken while a result is pending
  `OBMR_ASSERT(a_no_overlap, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "input ready while a result is pending")

  // the frame's last result ends the burst
  `OBMR_ASSERT(a_burst_end, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid, "result after the last area")

  `OBMR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid && !s_axis_tready, "handshake active during reset")

endmodule

bind ordinal_block_mean_rank obmr_chk u_obmr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
